FILE: rtl/cfsp_pkg.sv
// Shared types, codes and format tables for the class file stream parser.
`default_nettype none
package cfsp_pkg;

   localparam int unsigned POOL_DEPTH_DEF = 4096;
   localparam logic [31:0] CLASS_MAGIC    = 32'hCAFEBABE;

   // parser phases
   localparam logic [4:0] PH_HALT    = 5'd0;
   localparam logic [4:0] PH_MAGIC   = 5'd1;
   localparam logic [4:0] PH_MINOR   = 5'd2;
   localparam logic [4:0] PH_MAJOR   = 5'd3;
   localparam logic [4:0] PH_PCOUNT  = 5'd4;
   localparam logic [4:0] PH_TAG     = 5'd5;
   localparam logic [4:0] PH_PWORD   = 5'd6;
   localparam logic [4:0] PH_ULEN    = 5'd7;
   localparam logic [4:0] PH_UBYTE   = 5'd8;
   localparam logic [4:0] PH_ACCESS  = 5'd9;
   localparam logic [4:0] PH_THIS    = 5'd10;
   localparam logic [4:0] PH_SUPER   = 5'd11;
   localparam logic [4:0] PH_ICOUNT  = 5'd12;
   localparam logic [4:0] PH_IFACE   = 5'd13;
   localparam logic [4:0] PH_MCOUNT  = 5'd14;
   localparam logic [4:0] PH_MACC    = 5'd15;
   localparam logic [4:0] PH_MNAME   = 5'd16;
   localparam logic [4:0] PH_MDESC   = 5'd17;
   localparam logic [4:0] PH_MACOUNT = 5'd18;
   localparam logic [4:0] PH_CACOUNT = 5'd19;
   localparam logic [4:0] PH_ANAME   = 5'd20;
   localparam logic [4:0] PH_ALEN    = 5'd21;
   localparam logic [4:0] PH_ABYTE   = 5'd22;

   // sections
   localparam logic [2:0] SEC_HEADER = 3'd0;
   localparam logic [2:0] SEC_POOL   = 3'd1;
   localparam logic [2:0] SEC_IFACE  = 3'd2;
   localparam logic [2:0] SEC_FIELDS = 3'd3;
   localparam logic [2:0] SEC_METHOD = 3'd4;
   localparam logic [2:0] SEC_CATTR  = 3'd5;

   // result kinds
   localparam logic [4:0] KIND_MAGIC    = 5'd0;
   localparam logic [4:0] KIND_MINOR    = 5'd1;
   localparam logic [4:0] KIND_MAJOR    = 5'd2;
   localparam logic [4:0] KIND_COUNT    = 5'd3;
   localparam logic [4:0] KIND_TAG      = 5'd4;
   localparam logic [4:0] KIND_PWORD    = 5'd5;
   localparam logic [4:0] KIND_ULEN     = 5'd6;
   localparam logic [4:0] KIND_PAYLOAD  = 5'd7;
   localparam logic [4:0] KIND_ACCESS   = 5'd8;
   localparam logic [4:0] KIND_THIS     = 5'd9;
   localparam logic [4:0] KIND_SUPER    = 5'd10;
   localparam logic [4:0] KIND_IFACE    = 5'd11;
   localparam logic [4:0] KIND_NAME     = 5'd12;
   localparam logic [4:0] KIND_DESC     = 5'd13;
   localparam logic [4:0] KIND_ANAME    = 5'd14;
   localparam logic [4:0] KIND_ALEN     = 5'd15;
   localparam logic [4:0] KIND_ACOUNT   = 5'd16;
   localparam logic [4:0] KIND_ERROR    = 5'd17;
   localparam logic [4:0] KIND_DONE     = 5'd18;

   // error codes
   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_MAGIC     = 3'd1;
   localparam logic [2:0] ERR_TAG       = 3'd2;
   localparam logic [2:0] ERR_CLASS_IDX = 3'd3;
   localparam logic [2:0] ERR_POOL_SIZE = 3'd4;

   // constant pool tags
   localparam logic [7:0] TAG_UTF8    = 8'd1;
   localparam logic [7:0] TAG_INT     = 8'd3;
   localparam logic [7:0] TAG_FLOAT   = 8'd4;
   localparam logic [7:0] TAG_LONG    = 8'd5;
   localparam logic [7:0] TAG_DOUBLE  = 8'd6;
   localparam logic [7:0] TAG_CLASS   = 8'd7;
   localparam logic [7:0] TAG_STRING  = 8'd8;
   localparam logic [7:0] TAG_FREF    = 8'd9;
   localparam logic [7:0] TAG_MREF    = 8'd10;
   localparam logic [7:0] TAG_IMREF   = 8'd11;
   localparam logic [7:0] TAG_NTYPE   = 8'd12;
   localparam logic [7:0] TAG_MHANDLE = 8'd15;
   localparam logic [7:0] TAG_MTYPE   = 8'd16;
   localparam logic [7:0] TAG_INDY    = 8'd18;

   typedef struct packed {
      logic [2:0]  section;
      logic [4:0]  item_kind;
      logic [15:0] entry_index;
      logic [15:0] sub_index;
      logic [31:0] field_value;
      logic [4:0]  pool_tag;
      logic [2:0]  error_code;
      logic        last;
   } res_type;

   // byte width of word w of an entry with this tag, 0 past the last word
   function automatic logic [2:0] word_width(input logic [4:0] tag, input logic [1:0] w);
      logic [7:0] t;
      logic [2:0] r;
      t = {3'd0, tag};
      r = 3'd0;
      case (t)
         TAG_INT, TAG_FLOAT:       r = (w == 2'd0) ? 3'd4 : 3'd0;
         TAG_LONG, TAG_DOUBLE:     r = (w < 2'd2) ? 3'd4 : 3'd0;
         TAG_CLASS, TAG_STRING, TAG_MTYPE: r = (w == 2'd0) ? 3'd2 : 3'd0;
         TAG_FREF, TAG_MREF, TAG_IMREF, TAG_NTYPE, TAG_INDY:
            r = (w < 2'd2) ? 3'd2 : 3'd0;
         TAG_MHANDLE: r = (w == 2'd0) ? 3'd1 : ((w == 2'd1) ? 3'd2 : 3'd0);
         default: r = 3'd0;
      endcase
      return r;
   endfunction

   function automatic logic tag_known(input logic [7:0] t);
      logic k;
      k = 1'b0;
      case (t)
         TAG_UTF8, TAG_INT, TAG_FLOAT, TAG_LONG, TAG_DOUBLE, TAG_CLASS, TAG_STRING,
         TAG_FREF, TAG_MREF, TAG_IMREF, TAG_NTYPE, TAG_MHANDLE, TAG_MTYPE,
         TAG_INDY: k = 1'b1;
         default: k = 1'b0;
      endcase
      return k;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/cfsp_ram.sv
// Generic single write port RAM with registered read.
`default_nettype none
module cfsp_ram #(
   parameter int unsigned WIDTH = 1,
   parameter int unsigned DEPTH = cfsp_pkg::POOL_DEPTH_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

FILE: rtl/cfsp_core.sv
// Format walker: per-byte state update, pool valid store and super class index check.
`default_nettype none
module cfsp_core #(
   parameter int unsigned POOL_DEPTH = cfsp_pkg::POOL_DEPTH_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic [7:0]        data_byte,
   input  wire logic              start_flag,
   output logic                   push_valid,
   output cfsp_pkg::res_type      push_res
);
   localparam int unsigned AW = $clog2(POOL_DEPTH);
   localparam logic [16:0] DEPTH_W = 17'(POOL_DEPTH);

   logic [4:0]  phase_ff, phase_in;
   logic [1:0]  bpos_ff, bpos_in;
   logic [23:0] asm_ff, asm_in;
   logic [15:0] pcount_ff, pcount_in;
   logic [16:0] ppos_ff, ppos_in;
   logic [4:0]  tag_ff, tag_in;
   logic [15:0] items_ff, items_in;
   logic [15:0] attrs_ff, attrs_in;
   logic [31:0] bytes_ff, bytes_in;
   logic [1:0]  word_ff, word_in;
   logic [15:0] anum_ff, anum_in;
   logic [15:0] boff_ff, boff_in;
   logic [2:0]  msect_ff, msect_in;

   logic              chk_valid_ff, chk_valid_in;
   logic              chk_nz_ff, chk_nz_in;
   logic              chk_ge_ff, chk_ge_in;
   cfsp_pkg::res_type chk_res_ff, chk_res_in;
   logic              chk_bad;

   logic              core_valid;
   cfsp_pkg::res_type core_res;

   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic          ram_wdata;
   logic [AW-1:0] ram_raddr;
   logic          ram_rdata;

   cfsp_ram #(.WIDTH(1), .DEPTH(POOL_DEPTH)) u_valid_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      logic [4:0]  b_phase;
      logic [1:0]  b_bpos;
      logic [23:0] b_asm;
      logic [31:0] v;
      logic [2:0]  width;
      logic        act;
      logic        fin;
      logic        done;
      logic        do_entry_end;
      logic        do_attr_end;
      logic        do_members;
      logic        do_attrs;
      logic [16:0] step;
      logic [16:0] slot2;

      b_phase = start_flag ? cfsp_pkg::PH_MAGIC : phase_ff;
      b_bpos  = start_flag ? 2'd0 : bpos_ff;
      b_asm   = start_flag ? 24'd0 : asm_ff;
      act     = accept && (start_flag || (phase_ff != cfsp_pkg::PH_HALT));
      v       = {b_asm, data_byte};

      phase_in  = b_phase;
      bpos_in   = b_bpos;
      asm_in    = b_asm;
      pcount_in = start_flag ? 16'd0 : pcount_ff;
      ppos_in   = start_flag ? 17'd0 : ppos_ff;
      tag_in    = start_flag ? 5'd0 : tag_ff;
      items_in  = start_flag ? 16'd0 : items_ff;
      attrs_in  = start_flag ? 16'd0 : attrs_ff;
      bytes_in  = start_flag ? 32'd0 : bytes_ff;
      word_in   = start_flag ? 2'd0 : word_ff;
      anum_in   = start_flag ? 16'd0 : anum_ff;
      boff_in   = start_flag ? 16'd0 : boff_ff;
      msect_in  = start_flag ? 3'd0 : msect_ff;

      case (b_phase)
         cfsp_pkg::PH_MAGIC, cfsp_pkg::PH_ALEN: width = 3'd4;
         cfsp_pkg::PH_TAG, cfsp_pkg::PH_UBYTE, cfsp_pkg::PH_ABYTE: width = 3'd1;
         cfsp_pkg::PH_PWORD: begin
            width = cfsp_pkg::word_width(tag_in, word_in);
            if (width == 3'd0) width = 3'd1;
         end
         default: width = 3'd2;
      endcase

      fin          = act && (({1'b0, b_bpos} + 3'd1) >= width);
      done         = 1'b0;
      do_entry_end = 1'b0;
      do_attr_end  = 1'b0;
      do_members   = 1'b0;
      do_attrs     = 1'b0;
      step         = 17'd1;
      slot2        = 17'd0;

      ram_we    = 1'b0;
      ram_waddr = ppos_in[AW-1:0];
      ram_wdata = 1'b1;
      ram_raddr = v[AW-1:0];

      chk_valid_in = 1'b0;
      chk_nz_in    = v[15:0] != 16'd0;
      chk_ge_in    = (v[15:0] >= pcount_in) || ({1'b0, v[15:0]} >= DEPTH_W);

      core_valid           = fin;
      core_res.section     = cfsp_pkg::SEC_HEADER;
      core_res.item_kind   = cfsp_pkg::KIND_MAGIC;
      core_res.entry_index = 16'd0;
      core_res.sub_index   = 16'd0;
      core_res.field_value = v;
      core_res.pool_tag    = 5'd0;
      core_res.error_code  = cfsp_pkg::ERR_NONE;
      core_res.last        = 1'b0;

      if (act) begin
         bpos_in = b_bpos + 2'd1;
         asm_in  = v[23:0];
      end

      if (fin) begin
         bpos_in = 2'd0;
         asm_in  = 24'd0;
         case (b_phase)
            cfsp_pkg::PH_MAGIC: begin
               if (v != cfsp_pkg::CLASS_MAGIC) begin
                  core_res.item_kind  = cfsp_pkg::KIND_ERROR;
                  core_res.error_code = cfsp_pkg::ERR_MAGIC;
                  core_res.last       = 1'b1;
                  phase_in = cfsp_pkg::PH_HALT;
               end else begin
                  phase_in = cfsp_pkg::PH_MINOR;
               end
            end
            cfsp_pkg::PH_MINOR: begin
               core_res.item_kind = cfsp_pkg::KIND_MINOR;
               phase_in = cfsp_pkg::PH_MAJOR;
            end
            cfsp_pkg::PH_MAJOR: begin
               core_res.item_kind = cfsp_pkg::KIND_MAJOR;
               phase_in = cfsp_pkg::PH_PCOUNT;
            end
            cfsp_pkg::PH_PCOUNT: begin
               core_res.section   = cfsp_pkg::SEC_POOL;
               core_res.item_kind = cfsp_pkg::KIND_COUNT;
               if ({1'b0, v[15:0]} > DEPTH_W) begin
                  core_res.item_kind  = cfsp_pkg::KIND_ERROR;
                  core_res.error_code = cfsp_pkg::ERR_POOL_SIZE;
                  core_res.last       = 1'b1;
                  phase_in = cfsp_pkg::PH_HALT;
               end else begin
                  pcount_in = v[15:0];
                  ppos_in   = 17'd1;
                  phase_in  = (17'd1 >= {1'b0, v[15:0]}) ? cfsp_pkg::PH_ACCESS
                                                         : cfsp_pkg::PH_TAG;
               end
            end
            cfsp_pkg::PH_TAG: begin
               core_res.section     = cfsp_pkg::SEC_POOL;
               core_res.item_kind   = cfsp_pkg::KIND_TAG;
               core_res.entry_index = ppos_in[15:0];
               if (!cfsp_pkg::tag_known(v[7:0])) begin
                  core_res.item_kind  = cfsp_pkg::KIND_ERROR;
                  core_res.error_code = cfsp_pkg::ERR_TAG;
                  core_res.last       = 1'b1;
                  phase_in = cfsp_pkg::PH_HALT;
               end else begin
                  tag_in            = v[4:0];
                  core_res.pool_tag = v[4:0];
                  word_in           = 2'd0;
                  ram_we            = ppos_in < DEPTH_W;
                  phase_in = (v[7:0] == cfsp_pkg::TAG_UTF8) ? cfsp_pkg::PH_ULEN
                                                            : cfsp_pkg::PH_PWORD;
               end
            end
            cfsp_pkg::PH_PWORD: begin
               core_res.section     = cfsp_pkg::SEC_POOL;
               core_res.item_kind   = cfsp_pkg::KIND_PWORD;
               core_res.entry_index = ppos_in[15:0];
               core_res.sub_index   = {14'd0, word_in};
               core_res.pool_tag    = tag_in;
               word_in = word_in + 2'd1;
               if (cfsp_pkg::word_width(tag_in, word_in) == 3'd0) do_entry_end = 1'b1;
            end
            cfsp_pkg::PH_ULEN: begin
               core_res.section     = cfsp_pkg::SEC_POOL;
               core_res.item_kind   = cfsp_pkg::KIND_ULEN;
               core_res.entry_index = ppos_in[15:0];
               core_res.pool_tag    = tag_in;
               bytes_in = v;
               boff_in  = 16'd0;
               if (v == 32'd0) do_entry_end = 1'b1;
               else phase_in = cfsp_pkg::PH_UBYTE;
            end
            cfsp_pkg::PH_UBYTE: begin
               core_res.section     = cfsp_pkg::SEC_POOL;
               core_res.item_kind   = cfsp_pkg::KIND_PAYLOAD;
               core_res.entry_index = ppos_in[15:0];
               core_res.sub_index   = boff_in;
               core_res.pool_tag    = tag_in;
               boff_in  = boff_in + 16'd1;
               bytes_in = bytes_in - 32'd1;
               if (bytes_in == 32'd0) do_entry_end = 1'b1;
            end
            cfsp_pkg::PH_ACCESS: begin
               core_res.item_kind = cfsp_pkg::KIND_ACCESS;
               phase_in = cfsp_pkg::PH_THIS;
            end
            cfsp_pkg::PH_THIS: begin
               core_res.item_kind = cfsp_pkg::KIND_THIS;
               if (v == 32'd0) begin
                  core_res.item_kind  = cfsp_pkg::KIND_ERROR;
                  core_res.error_code = cfsp_pkg::ERR_CLASS_IDX;
                  core_res.last       = 1'b1;
                  phase_in = cfsp_pkg::PH_HALT;
               end else begin
                  phase_in = cfsp_pkg::PH_SUPER;
               end
            end
            cfsp_pkg::PH_SUPER: begin
               // hold the result in a register for the valid store read and push it in the next cycle
               core_res.item_kind = cfsp_pkg::KIND_SUPER;
               core_valid   = 1'b0;
               chk_valid_in = 1'b1;
               phase_in     = cfsp_pkg::PH_ICOUNT;
            end
            cfsp_pkg::PH_ICOUNT: begin
               core_res.section   = cfsp_pkg::SEC_IFACE;
               core_res.item_kind = cfsp_pkg::KIND_COUNT;
               items_in = v[15:0];
               ppos_in  = 17'd0;
               if (v[15:0] == 16'd0) begin
                  msect_in = cfsp_pkg::SEC_FIELDS;
                  phase_in = cfsp_pkg::PH_MCOUNT;
               end else begin
                  phase_in = cfsp_pkg::PH_IFACE;
               end
            end
            cfsp_pkg::PH_IFACE: begin
               core_res.section     = cfsp_pkg::SEC_IFACE;
               core_res.item_kind   = cfsp_pkg::KIND_IFACE;
               core_res.entry_index = ppos_in[15:0];
               ppos_in  = {1'b0, ppos_in[15:0] + 16'd1};
               items_in = items_in - 16'd1;
               if (items_in == 16'd0) begin
                  msect_in = cfsp_pkg::SEC_FIELDS;
                  phase_in = cfsp_pkg::PH_MCOUNT;
               end
            end
            cfsp_pkg::PH_MCOUNT: begin
               core_res.section   = msect_in;
               core_res.item_kind = cfsp_pkg::KIND_COUNT;
               items_in   = v[15:0];
               ppos_in    = 17'd0;
               do_members = 1'b1;
            end
            cfsp_pkg::PH_MACC: begin
               core_res.section     = msect_in;
               core_res.item_kind   = cfsp_pkg::KIND_ACCESS;
               core_res.entry_index = ppos_in[15:0];
               phase_in = cfsp_pkg::PH_MNAME;
            end
            cfsp_pkg::PH_MNAME: begin
               core_res.section     = msect_in;
               core_res.item_kind   = cfsp_pkg::KIND_NAME;
               core_res.entry_index = ppos_in[15:0];
               phase_in = cfsp_pkg::PH_MDESC;
            end
            cfsp_pkg::PH_MDESC: begin
               core_res.section     = msect_in;
               core_res.item_kind   = cfsp_pkg::KIND_DESC;
               core_res.entry_index = ppos_in[15:0];
               phase_in = cfsp_pkg::PH_MACOUNT;
            end
            cfsp_pkg::PH_MACOUNT, cfsp_pkg::PH_CACOUNT: begin
               core_res.section     = msect_in;
               core_res.item_kind   = cfsp_pkg::KIND_ACOUNT;
               core_res.entry_index = (b_phase == cfsp_pkg::PH_MACOUNT) ? ppos_in[15:0]
                                                                        : 16'd0;
               attrs_in = v[15:0];
               anum_in  = 16'd0;
               do_attrs = 1'b1;
            end
            cfsp_pkg::PH_ANAME: begin
               core_res.section     = msect_in;
               core_res.item_kind   = cfsp_pkg::KIND_ANAME;
               core_res.entry_index = anum_in;
               phase_in = cfsp_pkg::PH_ALEN;
            end
            cfsp_pkg::PH_ALEN: begin
               core_res.section     = msect_in;
               core_res.item_kind   = cfsp_pkg::KIND_ALEN;
               core_res.entry_index = anum_in;
               core_res.sub_index   = 16'd1;
               bytes_in = v;
               boff_in  = 16'd0;
               if (v == 32'd0) do_attr_end = 1'b1;
               else phase_in = cfsp_pkg::PH_ABYTE;
            end
            cfsp_pkg::PH_ABYTE: begin
               core_res.section     = msect_in;
               core_res.item_kind   = cfsp_pkg::KIND_PAYLOAD;
               core_res.entry_index = anum_in;
               core_res.sub_index   = boff_in;
               boff_in  = boff_in + 16'd1;
               bytes_in = bytes_in - 32'd1;
               if (bytes_in == 32'd0) do_attr_end = 1'b1;
            end
            default: begin
               core_valid = 1'b0;
               phase_in   = cfsp_pkg::PH_HALT;
            end
         endcase

         if (do_entry_end) begin
            if ((tag_in == cfsp_pkg::TAG_LONG[4:0]) ||
                (tag_in == cfsp_pkg::TAG_DOUBLE[4:0])) begin
               step  = 17'd2;
               slot2 = ppos_in + 17'd1;
               // second slot of a two-slot entry is not a valid index
               if ((slot2 < {1'b0, pcount_in}) && (slot2 < DEPTH_W)) begin
                  ram_we    = 1'b1;
                  ram_waddr = slot2[AW-1:0];
                  ram_wdata = 1'b0;
               end
            end
            ppos_in  = ppos_in + step;
            phase_in = (ppos_in >= {1'b0, pcount_in}) ? cfsp_pkg::PH_ACCESS
                                                      : cfsp_pkg::PH_TAG;
         end

         if (do_attr_end) begin
            attrs_in = attrs_in - 16'd1;
            anum_in  = anum_in + 16'd1;
            do_attrs = 1'b1;
         end

         if (do_attrs) begin
            if (attrs_in == 16'd0) begin
               if (msect_in == cfsp_pkg::SEC_CATTR) begin
                  done     = 1'b1;
                  phase_in = cfsp_pkg::PH_HALT;
               end else begin
                  ppos_in    = {1'b0, ppos_in[15:0] + 16'd1};
                  items_in   = items_in - 16'd1;
                  do_members = 1'b1;
               end
            end else begin
               phase_in = cfsp_pkg::PH_ANAME;
            end
         end

         if (do_members) begin
            if (items_in == 16'd0) begin
               if (msect_in == cfsp_pkg::SEC_FIELDS) begin
                  msect_in = cfsp_pkg::SEC_METHOD;
                  phase_in = cfsp_pkg::PH_MCOUNT;
               end else begin
                  msect_in = cfsp_pkg::SEC_CATTR;
                  phase_in = cfsp_pkg::PH_CACOUNT;
               end
            end else begin
               phase_in = cfsp_pkg::PH_MACC;
            end
         end

         if (done) begin
            core_res.item_kind = cfsp_pkg::KIND_DONE;
            core_res.last      = 1'b1;
         end
      end

      chk_res_in = core_res;

      // a failed super check halts unless a restart arrives in the same cycle
      chk_bad = chk_nz_ff && (chk_ge_ff || !ram_rdata);
      if (chk_valid_ff && chk_bad && !(accept && start_flag)) begin
         phase_in = cfsp_pkg::PH_HALT;
      end

      push_valid = chk_valid_ff || core_valid;
      push_res   = core_res;
      if (chk_valid_ff) begin
         push_res = chk_res_ff;
         if (chk_bad) begin
            push_res.item_kind  = cfsp_pkg::KIND_ERROR;
            push_res.error_code = cfsp_pkg::ERR_CLASS_IDX;
            push_res.last       = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= cfsp_pkg::PH_HALT;
         bpos_ff      <= 2'd0;
         asm_ff       <= 24'd0;
         pcount_ff    <= 16'd0;
         ppos_ff      <= 17'd0;
         tag_ff       <= 5'd0;
         items_ff     <= 16'd0;
         attrs_ff     <= 16'd0;
         bytes_ff     <= 32'd0;
         word_ff      <= 2'd0;
         anum_ff      <= 16'd0;
         boff_ff      <= 16'd0;
         msect_ff     <= 3'd0;
         chk_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff  <= phase_in;
            bpos_ff   <= bpos_in;
            asm_ff    <= asm_in;
            pcount_ff <= pcount_in;
            ppos_ff   <= ppos_in;
            tag_ff    <= tag_in;
            items_ff  <= items_in;
            attrs_ff  <= attrs_in;
            bytes_ff  <= bytes_in;
            word_ff   <= word_in;
            anum_ff   <= anum_in;
            boff_ff   <= boff_in;
            msect_ff  <= msect_in;
         end else if (chk_valid_ff && chk_bad) begin
            phase_ff <= cfsp_pkg::PH_HALT;
         end
         chk_valid_ff <= chk_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (chk_valid_in) begin
         chk_nz_ff  <= chk_nz_in;
         chk_ge_ff  <= chk_ge_in;
         chk_res_ff <= chk_res_in;
      end
   end

   a_chk_alone: assert property (@(posedge clock) disable iff (reset)
      chk_valid_ff |-> !core_valid)
      else $error("field result collides with pending super class index check");

   a_chk_halt: assert property (@(posedge clock) disable iff (reset)
      (chk_valid_ff && chk_bad && !(accept && start_flag)) |=>
         (phase_ff == cfsp_pkg::PH_HALT))
      else $error("parser did not halt after bad super class index");

   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      (push_valid && push_res.last) |->
         (push_res.item_kind == cfsp_pkg::KIND_ERROR || push_res.item_kind == cfsp_pkg::KIND_DONE))
      else $error("last flag on a result that is neither done nor error");

   a_super_chk: assert property (@(posedge clock) disable iff (reset)
      chk_valid_ff |-> !$past(chk_valid_ff))
      else $error("back to back super class index checks");

endmodule
`default_nettype wire

FILE: rtl/class_file_stream_parser.sv
// Top level: byte stream in, tagged field words out through a two-entry result queue.
// Results: a result enters the queue registers with the byte that completes its field; the
// super class result first waits in the check register on the pool valid store read.
// Throughput: one byte per cycle; req_stall rises only while both queue entries hold words.
// Reset: parser halted until a byte with the start flag, result queue empty. The pool
// valid store is not cleared; only slots written earlier in the same file are read.
`default_nettype none
module class_file_stream_parser #(
   parameter int unsigned POOL_DEPTH = cfsp_pkg::POOL_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_start_flag,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_section,
   output logic [4:0]       rsp_item_kind,
   output logic [15:0]      rsp_entry_index,
   output logic [15:0]      rsp_sub_index,
   output logic [31:0]      rsp_field_value,
   output logic [4:0]       rsp_pool_tag,
   output logic [2:0]       rsp_error_code,
   output logic             rsp_last
);
   logic              accept;
   logic              push_valid;
   cfsp_pkg::res_type push_res;
   logic              pop;

   logic [1:0]        count_ff, count_in;
   cfsp_pkg::res_type slot0_ff, slot0_in;
   cfsp_pkg::res_type slot1_ff, slot1_in;

   cfsp_core #(.POOL_DEPTH(POOL_DEPTH)) u_core (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .data_byte  (req_data_byte),
      .start_flag (req_start_flag),
      .push_valid (push_valid),
      .push_res   (push_res)
   );

   assign req_stall = count_ff == 2'd2;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = count_ff != 2'd0;
   assign pop       = rsp_valid && !rsp_stall;

   always_comb begin
      logic [1:0] after_pop;
      after_pop = count_ff - {1'b0, pop};
      slot0_in  = pop ? slot1_ff : slot0_ff;
      slot1_in  = slot1_ff;
      if (push_valid) begin
         if (after_pop == 2'd0) slot0_in = push_res;
         else slot1_in = push_res;
      end
      count_in = after_pop + {1'b0, push_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign rsp_section     = slot0_ff.section;
   assign rsp_item_kind   = slot0_ff.item_kind;
   assign rsp_entry_index = slot0_ff.entry_index;
   assign rsp_sub_index   = slot0_ff.sub_index;
   assign rsp_field_value = slot0_ff.field_value;
   assign rsp_pool_tag    = slot0_ff.pool_tag;
   assign rsp_error_code  = slot0_ff.error_code;
   assign rsp_last        = slot0_ff.last;

endmodule
`default_nettype wire
